@@ design/pbef_pkg.sv @@
// ----------------------------------------------------------------------------
// pbef_pkg: shared types and constants for the polygon blocking edge finder
// Field widths, command and status codes, and the command queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package pbef_pkg;
	localparam int MAX_VERTICES = 16;
	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int W = 16;
	localparam int DW = W + 1;
	localparam int MW = 2 * DW;
	localparam int PW = MW + 1;
	localparam int MBW = 36;
	localparam int ACCW = 104;
	localparam int QDEPTH = 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NO_FWD = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic signed [W-1:0] vx;
		logic signed [W-1:0] vy;
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [W-1:0] tcx;
		logic signed [W-1:0] tcy;
	} cmd_t;
endpackage
`default_nettype wire

@@ design/polygon_blocking_edge_finder_top.sv @@
// ----------------------------------------------------------------------------
// polygon_blocking_edge_finder_top: polygon contact best edge selection
// Stores a polygon and reports the vertex and neighbour of the blocking edge.
// ----------------------------------------------------------------------------
// Usage. A transaction is accepted at a rising edge where start is high and
// busy is low. op selects clear, append vertex or query; other codes are
// ignored. Only a query produces a result, shown for exactly one cycle with
// done high; the receiver cannot stall, so results are never held.
// A front stage decodes the transaction, forms the query direction and puts
// it in a two-entry command queue; busy is high only while that queue is
// full. The back stage owns the vertex store and executes commands in order.
// Clear and append pass through the queue and are then executed by the back
// stage. A query scans the projection of every stored vertex, then forms the
// wide edge products bit-serially; with a zero-length edge the products are
// skipped. The projection scan goes through the single store read port and
// the shared 17 x 17 multiplier. A query on an empty polygon is answered
// without a scan, with status empty.
// Reset clears the vertex count and the queue; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_blocking_edge_finder_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] op,
	input wire logic signed [15:0] vertex_x,
	input wire logic signed [15:0] vertex_y,
	input wire logic colliding,
	input wire logic signed [15:0] mtd_x,
	input wire logic signed [15:0] mtd_y,
	input wire logic signed [15:0] source_cx,
	input wire logic signed [15:0] source_cy,
	input wire logic signed [15:0] target_cx,
	input wire logic signed [15:0] target_cy,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] first_index,
	output logic signed [15:0] first_x,
	output logic signed [15:0] first_y,
	output logic signed [15:0] second_x,
	output logic signed [15:0] second_y
);
	logic q_valid;
	logic q_pop;
	pbef_pkg::cmd_t q_cmd;

	// Front: decode and queue.
	pbef_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .colliding(colliding),
		.mtd_x(mtd_x), .mtd_y(mtd_y), .source_cx(source_cx), .source_cy(source_cy),
		.target_cx(target_cx), .target_cy(target_cy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	// Back: store, scan and edge choice.
	pbef_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
		.done(done), .status(status), .first_index(first_index),
		.first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y)
	);

	// Every result carries one of the defined status codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == pbef_pkg::ST_FOUND || status == pbef_pkg::ST_NO_FWD
		|| status == pbef_pkg::ST_EMPTY))
		else $error("result with an undefined status code");

	// An empty polygon reports all-zero vertex fields.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == pbef_pkg::ST_EMPTY) |->
		(first_index == 4'd0 && first_x == 16'sd0 && second_y == 16'sd0))
		else $error("empty polygon result carries vertex data");

	// The queue is never popped when empty.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("command queue popped while empty");
endmodule
`default_nettype wire

@@ design/pbef_front.sv @@
// ----------------------------------------------------------------------------
// pbef_front: command decode and queue
// Accepts items, forms the query direction and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module pbef_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] op,
	input wire logic signed [15:0] vertex_x,
	input wire logic signed [15:0] vertex_y,
	input wire logic colliding,
	input wire logic signed [15:0] mtd_x,
	input wire logic signed [15:0] mtd_y,
	input wire logic signed [15:0] source_cx,
	input wire logic signed [15:0] source_cy,
	input wire logic signed [15:0] target_cx,
	input wire logic signed [15:0] target_cy,
	output logic q_valid,
	output pbef_pkg::cmd_t q_cmd,
	input wire logic q_pop
);
	pbef_pkg::cmd_t entry_q [pbef_pkg::QDEPTH];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic push;
	pbef_pkg::cmd_t cmd_c;

	assign busy = (cnt_q == 2'(pbef_pkg::QDEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = entry_q[rptr_q];

	// Unused op codes are dropped here and never reach the queue.
	assign push = start && !busy && (op == pbef_pkg::OP_CLEAR || op == pbef_pkg::OP_APPEND
		|| op == pbef_pkg::OP_QUERY);

	always_comb begin
		cmd_c.kind = pbef_pkg::CMD_CLEAR;
		unique case (op)
			pbef_pkg::OP_APPEND: cmd_c.kind = pbef_pkg::CMD_APPEND;
			pbef_pkg::OP_QUERY: cmd_c.kind = pbef_pkg::CMD_QUERY;
			default: cmd_c.kind = pbef_pkg::CMD_CLEAR;
		endcase
		cmd_c.vx = vertex_x;
		cmd_c.vy = vertex_y;
		if (colliding) begin
			cmd_c.dx = {mtd_x[15], mtd_x};
			cmd_c.dy = {mtd_y[15], mtd_y};
		end else begin
			cmd_c.dx = {source_cx[15], source_cx} - {target_cx[15], target_cx};
			cmd_c.dy = {source_cy[15], source_cy} - {target_cy[15], target_cy};
		end
		cmd_c.tcx = target_cx;
		cmd_c.tcy = target_cy;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= cmd_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

@@ design/pbef_back.sv @@
// ----------------------------------------------------------------------------
// pbef_back: vertex store and query sequencer
// Holds the polygon, scans projections and selects the blocking edge.
// ----------------------------------------------------------------------------
`default_nettype none
module pbef_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire pbef_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] first_index,
	output logic signed [15:0] first_x,
	output logic signed [15:0] first_y,
	output logic signed [15:0] second_x,
	output logic signed [15:0] second_y
);
	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_SC_RD = 12'b000000000010,
		S_SC_M1 = 12'b000000000100,
		S_SC_M2 = 12'b000000001000,
		S_F_RD = 12'b000000010000,
		S_N_RD = 12'b000000100000,
		S_P_RD = 12'b000001000000,
		S_P_LD = 12'b000010000000,
		S_EDGE = 12'b000100000000,
		S_DEC = 12'b001000000000,
		S_SQ = 12'b010000000000,
		S_SEC = 12'b100000000000
	} state_t;

	localparam int W = pbef_pkg::W;
	localparam int DW = pbef_pkg::DW;
	localparam int PW = pbef_pkg::PW;
	localparam int IW = pbef_pkg::IW;
	localparam int CW = pbef_pkg::CW;
	localparam int ACCW = pbef_pkg::ACCW;
	localparam int MBW = pbef_pkg::MBW;

	state_t state_q;
	logic out_q;
	logic [2*W-1:0] mem [pbef_pkg::MAX_VERTICES];
	logic [2*W-1:0] rd_q;
	logic [IW-1:0] addr_c;
	logic [CW-1:0] count_q;
	logic [IW-1:0] i_q, first_q, nxt_q, prv_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic signed [W-1:0] tcx_q, tcy_q;
	logic signed [PW-1:0] best_q;
	logic [1:0] st_q;
	logic signed [W-1:0] fx_q, fy_q, nx_q, ny_q, px_q, py_q;
	logic signed [DW-1:0] enx_q, eny_q, epx_q, epy_q;
	logic [2:0] k_q;
	logic signed [2*DW-1:0] t_q;
	logic [MBW-1:0] dn_q, dp_q, en2_q, ep2_q;
	logic [ACCW-1:0] acc_q, mcand_q, lhs_q, acc_n;
	logic [MBW-1:0] mplier_q;
	logic [5:0] cnt_q;
	logic [1:0] ph_q;
	logic tn_q;
	logic signed [DW-1:0] ma, mb;
	logic signed [2*DW-1:0] prod;
	logic signed [PW-1:0] sum;
	logic signed [W-1:0] rx, ry;

	assign rx = rd_q[2*W-1:W];
	assign ry = rd_q[W-1:0];
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign done = out_q;

	always_comb begin
		priority case (1'b1)
			(state_q == S_F_RD): addr_c = first_q;
			(state_q == S_N_RD): addr_c = nxt_q;
			(state_q == S_P_RD): addr_c = prv_q;
			default: addr_c = i_q;
		endcase
	end

	// One shared 17 x 17 multiplier; the edge phase steps its operands by k.
	always_comb begin
		ma = dx_q;
		mb = {rx[W-1], rx} - {tcx_q[W-1], tcx_q};
		if (state_q == S_SC_M2) begin
			ma = dy_q;
			mb = {ry[W-1], ry} - {tcy_q[W-1], tcy_q};
		end else if (state_q == S_EDGE) begin
			unique case (k_q)
				3'd0: begin ma = dx_q; mb = enx_q; end
				3'd1: begin ma = dy_q; mb = eny_q; end
				3'd2: begin ma = dx_q; mb = epx_q; end
				3'd3: begin ma = dy_q; mb = epy_q; end
				3'd4: begin ma = enx_q; mb = enx_q; end
				3'd5: begin ma = eny_q; mb = eny_q; end
				3'd6: begin ma = epx_q; mb = epx_q; end
				default: begin ma = epy_q; mb = epy_q; end
			endcase
		end
		prod = ma * mb;
		sum = {t_q[2*DW-1], t_q} + {prod[2*DW-1], prod};
		acc_n = {acc_q[ACCW-2:0], 1'b0} + (mplier_q[MBW-1] ? mcand_q : '0);
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[addr_c];
		if (state_q == S_IDLE && q_valid && q_cmd.kind == pbef_pkg::CMD_APPEND
			&& count_q < CW'(pbef_pkg::MAX_VERTICES)) begin
			mem[count_q[IW-1:0]] <= {q_cmd.vx, q_cmd.vy};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dx_q <= q_cmd.dx;
				dy_q <= q_cmd.dy;
				tcx_q <= q_cmd.tcx;
				tcy_q <= q_cmd.tcy;
			end
			S_SC_M1: t_q <= prod;
			S_F_RD: begin
				nxt_q <= (CW'(first_q) + 1'b1 == count_q) ? '0 : first_q + 1'b1;
				prv_q <= (first_q == '0) ? IW'(count_q - 1'b1) : first_q - 1'b1;
			end
			S_N_RD: begin fx_q <= rx; fy_q <= ry; end
			S_P_RD: begin nx_q <= rx; ny_q <= ry; end
			S_P_LD: begin
				// The previous vertex is on the read port now; keep it for the result.
				px_q <= rx;
				py_q <= ry;
				enx_q <= {nx_q[W-1], nx_q} - {fx_q[W-1], fx_q};
				eny_q <= {ny_q[W-1], ny_q} - {fy_q[W-1], fy_q};
				epx_q <= {rx[W-1], rx} - {fx_q[W-1], fx_q};
				epy_q <= {ry[W-1], ry} - {fy_q[W-1], fy_q};
			end
			S_EDGE: begin
				if (!k_q[0]) begin
					t_q <= prod;
				end else begin
					unique case (k_q[2:1])
						2'd0: dn_q <= sum[PW-1] ? MBW'(-sum) : MBW'(sum);
						2'd1: dp_q <= sum[PW-1] ? MBW'(-sum) : MBW'(sum);
						2'd2: en2_q <= MBW'(sum);
						default: ep2_q <= MBW'(sum);
					endcase
				end
			end
			S_DEC: begin
				acc_q <= '0;
				mcand_q <= ACCW'(dn_q);
				mplier_q <= dn_q;
			end
			S_SQ: begin
				if (cnt_q == 6'(MBW - 1)) begin
					acc_q <= '0;
					unique case (ph_q)
						2'd0: begin mcand_q <= acc_n; mplier_q <= ep2_q; end
						2'd1: begin
							lhs_q <= acc_n;
							mcand_q <= ACCW'(dp_q);
							mplier_q <= dp_q;
						end
						2'd2: begin mcand_q <= acc_n; mplier_q <= en2_q; end
						default: ;
					endcase
				end else begin
					acc_q <= acc_n;
					mplier_q <= {mplier_q[MBW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_q <= 1'b0;
			i_q <= '0;
			first_q <= '0;
			best_q <= '0;
			st_q <= pbef_pkg::ST_EMPTY;
			k_q <= '0;
			cnt_q <= '0;
			ph_q <= '0;
			tn_q <= 1'b0;
			status <= pbef_pkg::ST_EMPTY;
			first_index <= '0;
			first_x <= '0;
			first_y <= '0;
			second_x <= '0;
			second_y <= '0;
		end else begin
			// A result leaves either from the last sequencer step or at once
			// for a query on an empty polygon.
			out_q <= (state_q == S_SEC) || (state_q == S_IDLE && q_valid
				&& q_cmd.kind == pbef_pkg::CMD_QUERY && count_q == '0);
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.kind)
							pbef_pkg::CMD_CLEAR: count_q <= '0;
							pbef_pkg::CMD_APPEND: begin
								if (count_q < CW'(pbef_pkg::MAX_VERTICES)) begin
									count_q <= count_q + 1'b1;
								end
							end
							default: begin
								if (count_q == '0) begin
									status <= pbef_pkg::ST_EMPTY;
									first_index <= '0;
									first_x <= '0;
									first_y <= '0;
									second_x <= '0;
									second_y <= '0;
								end else begin
									i_q <= '0;
									first_q <= '0;
									best_q <= '0;
									st_q <= pbef_pkg::ST_NO_FWD;
									state_q <= S_SC_RD;
								end
							end
						endcase
					end
				end
				S_SC_RD: state_q <= S_SC_M1;
				S_SC_M1: state_q <= S_SC_M2;
				S_SC_M2: begin
					// Strictly larger keeps the first of equal maxima.
					if (sum > best_q) begin
						best_q <= sum;
						first_q <= i_q;
						st_q <= pbef_pkg::ST_FOUND;
					end
					if (CW'(i_q) + 1'b1 == count_q) begin
						state_q <= S_F_RD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_F_RD: state_q <= S_N_RD;
				S_N_RD: state_q <= S_P_RD;
				S_P_RD: state_q <= S_P_LD;
				S_P_LD: begin
					k_q <= '0;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					cnt_q <= '0;
					ph_q <= '0;
					if (en2_q == '0) begin
						tn_q <= (ep2_q != '0) && (dp_q != '0);
						state_q <= S_SEC;
					end else if (ep2_q == '0) begin
						tn_q <= 1'b0;
						state_q <= S_SEC;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == 6'(MBW - 1)) begin
						cnt_q <= '0;
						ph_q <= ph_q + 1'b1;
						if (ph_q == 2'd3) begin
							tn_q <= (lhs_q < acc_n) && (acc_n != '0);
							state_q <= S_SEC;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					// Both neighbours are held in registers; the result follows.
					status <= st_q;
					first_index <= 4'(first_q);
					first_x <= fx_q;
					first_y <= fy_q;
					second_x <= tn_q ? nx_q : px_q;
					second_y <= tn_q ? ny_q : py_q;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
